>>> hdl/psd_pkg.sv
// Shared types and constants for the point-to-segment distance core.
`timescale 1ns / 1ps
package psd_pkg;

   localparam int REGION_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [REGION_BITS-1:0] {
      REGION_A   = 2'd0,
      REGION_B   = 2'd1,
      REGION_MID = 2'd2
   } region_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_A_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_A_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_A_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_B_X = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_B_Y = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_B_Z = 3'd5;

endpackage

>>> hdl/psd_req_if.sv
// Query point channel interface.
`timescale 1ns / 1ps
interface psd_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] query_x;
   logic signed [COORD_BITS-1:0] query_y;
   logic signed [COORD_BITS-1:0] query_z;

   modport source (output valid, output query_x, output query_y, output query_z,
                   input ready);
   modport sink (input valid, input query_x, input query_y, input query_z,
                 output ready);
endinterface

>>> hdl/psd_rsp_if.sv
// Distance result channel interface.
`timescale 1ns / 1ps
interface psd_rsp_if #(parameter int COORD_BITS = 16);
   logic                    valid;
   logic                    ready;
   logic [2*COORD_BITS+1:0] squared_distance;
   logic [COORD_BITS:0]     root_distance;
   logic [1:0]              region;

   modport source (output valid, output squared_distance, output root_distance,
                   output region, input ready);
   modport sink (input valid, input squared_distance, input root_distance,
                 input region, output ready);
endinterface

>>> hdl/point_segment_distance_core.sv
// Top level of the point-to-segment squared distance core.
//
//  channel  | direction | transaction
//  ---------+-----------+-------------------------------------------------
//  req_if   | in        | query point (query_x, query_y, query_z)
//  rsp_if   | out       | squared_distance, root_distance, region
//  csr_*    | in        | endpoint register write, index 0..5, no read-back
//
// One query accepted per cycle sustained while rsp_if.ready stays high. A
// query goes from req to rsp through 3 front stages, the two-entry queue,
// 2*COORD_BITS+2 quotient, 1 correction and COORD_BITS+1 root stages.
// Synchronous reset clears the valid bits and loads endpoints A=(0,0,0),
// B=(1,0,0). A stalled rsp freezes the back end; the two-entry queue
// keeps the front end running and holds req_if.ready low only when full.
`timescale 1ns / 1ps
module point_segment_distance_core #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [psd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]              csr_wdata,
   psd_req_if.sink                            req_if,
   psd_rsp_if.source                          rsp_if
);
   import psd_pkg::*;

   localparam int REC_W = 3 * (2 * COORD_BITS + 2) + REGION_BITS;

   logic             f_valid, f_ready;
   logic [REC_W-1:0] f_rec;
   logic             q_valid, q_ready;
   logic [REC_W-1:0] q_rec;

   psd_front #(.COORD_BITS(COORD_BITS), .REC_W(REC_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_rec   (f_rec)
   );

   psd_fifo #(.WIDTH(REC_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_rec),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_rec)
   );

   psd_back #(.COORD_BITS(COORD_BITS), .REC_W(REC_W)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_rec   (q_rec),
      .rsp_if   (rsp_if)
   );

endmodule

>>> hdl/psd_front.sv
// Front end: endpoint registers, differences, dot products and region select.
`timescale 1ns / 1ps
module psd_front #(
   parameter int COORD_BITS = 16,
   parameter int REC_W      = 3 * (2 * COORD_BITS + 2) + 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [psd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [COORD_BITS-1:0]               csr_wdata,
   psd_req_if.sink                             req_if,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [REC_W-1:0]                    out_rec
);
   import psd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int W  = 2 * COORD_BITS + 2;
   localparam int EW = W + 1;

   typedef struct packed {
      logic [W-1:0] base;
      logic [W-1:0] e;
      logic [W-1:0] f;
      region_type   region;
   } rec_type;

   logic signed [COORD_BITS-1:0] a_ff [3];
   logic signed [COORD_BITS-1:0] b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff[0] <= '0;
         a_ff[1] <= '0;
         a_ff[2] <= '0;
         b_ff[0] <= COORD_BITS'(1);
         b_ff[1] <= '0;
         b_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_END_A_X: a_ff[0] <= csr_wdata;
            CSR_END_A_Y: a_ff[1] <= csr_wdata;
            CSR_END_A_Z: a_ff[2] <= csr_wdata;
            CSR_END_B_X: b_ff[0] <= csr_wdata;
            CSR_END_B_Y: b_ff[1] <= csr_wdata;
            CSR_END_B_Z: b_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3         = !v3_ff || out_ready;
   assign rdy2         = !v2_ff || rdy3;
   assign rdy1         = !v1_ff || rdy2;
   assign req_if.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_if.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: coordinate differences
   logic signed [COORD_BITS-1:0] q_in [3];
   logic signed [DW-1:0] ab_ff [3], ac_ff [3], bc_ff [3];

   assign q_in[0] = req_if.query_x;
   assign q_in[1] = req_if.query_y;
   assign q_in[2] = req_if.query_z;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= DW'(b_ff[i]) - DW'(a_ff[i]);
            ac_ff[i] <= DW'(q_in[i]) - DW'(a_ff[i]);
            bc_ff[i] <= DW'(q_in[i]) - DW'(b_ff[i]);
         end
      end
   end

   // stage 2: per-axis products
   logic signed [W-1:0] pe_ff [3], pa_ff [3], pb_ff [3], pf_ff [3];

   always_ff @(posedge clock) begin
      if (rdy2) begin
         for (int i = 0; i < 3; i++) begin
            pe_ff[i] <= W'(ac_ff[i]) * W'(ab_ff[i]);
            pa_ff[i] <= W'(ac_ff[i]) * W'(ac_ff[i]);
            pb_ff[i] <= W'(bc_ff[i]) * W'(bc_ff[i]);
            pf_ff[i] <= W'(ab_ff[i]) * W'(ab_ff[i]);
         end
      end
   end

   // stage 3: sums and region decision
   logic signed [EW-1:0] e_sum;
   logic [W-1:0]         acac, bcbc, ff_sum;
   rec_type              rec_in, rec_ff;

   always_comb begin
      e_sum  = EW'(pe_ff[0]) + EW'(pe_ff[1]) + EW'(pe_ff[2]);
      acac   = pa_ff[0] + pa_ff[1] + pa_ff[2];
      bcbc   = pb_ff[0] + pb_ff[1] + pb_ff[2];
      ff_sum = pf_ff[0] + pf_ff[1] + pf_ff[2];
      rec_in.f = ff_sum;
      if (e_sum <= 0) begin
         rec_in.region = REGION_A;
         rec_in.base   = acac;
         rec_in.e      = '0;
      end else if (e_sum >= $signed({1'b0, ff_sum})) begin
         rec_in.region = REGION_B;
         rec_in.base   = bcbc;
         rec_in.e      = '0;
      end else begin
         rec_in.region = REGION_MID;
         rec_in.base   = acac;
         rec_in.e      = e_sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) rec_ff <= rec_in;
   end

   assign out_valid = v3_ff;
   assign out_rec   = rec_ff;

endmodule

>>> hdl/psd_fifo.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module psd_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

>>> hdl/psd_back.sv
// Back end: pipelined e*e/f quotient, interior correction and square root.
`timescale 1ns / 1ps
module psd_back #(
   parameter int COORD_BITS = 16,
   parameter int REC_W      = 3 * (2 * COORD_BITS + 2) + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [REC_W-1:0] in_rec,
   psd_rsp_if.source        rsp_if
);
   import psd_pkg::*;

   localparam int W  = 2 * COORD_BITS + 2;
   localparam int RB = COORD_BITS + 1;

   typedef struct packed {
      logic [W-1:0] base;
      logic [W-1:0] e;
      logic [W-1:0] f;
      region_type   region;
   } rec_type;

   logic en;
   logic out_v;

   assign en       = !out_v || rsp_if.ready;
   assign in_ready = en;

   // quotient chain: one bit of e per stage, remainder kept below f
   logic         s_v   [0:W];
   logic [W-1:0] s_r   [0:W];
   logic [W-1:0] s_q   [0:W];
   rec_type      s_rec [0:W];

   logic         dv_ff   [0:W-1];
   logic [W-1:0] dr_ff   [0:W-1];
   logic [W-1:0] dq_ff   [0:W-1];
   rec_type      drec_ff [0:W-1];

   assign s_v[0]   = in_valid;
   assign s_r[0]   = '0;
   assign s_q[0]   = '0;
   assign s_rec[0] = in_rec;

   for (genvar j = 0; j < W; j++) begin : g_div
      logic [W+1:0] t, f1, f2;
      logic [W-1:0] r_in, q_in;
      logic [1:0]   k;

      always_comb begin
         t  = {1'b0, s_r[j], 1'b0} +
              (s_rec[j].e[W-1-j] ? {2'b00, s_rec[j].e} : '0);
         f1 = {2'b00, s_rec[j].f};
         f2 = {1'b0, s_rec[j].f, 1'b0};
         if (t >= f2) begin
            r_in = W'(t - f2);
            k    = 2'd2;
         end else if (t >= f1) begin
            r_in = W'(t - f1);
            k    = 2'd1;
         end else begin
            r_in = t[W-1:0];
            k    = 2'd0;
         end
         q_in = {s_q[j][W-2:0], 1'b0} + W'(k);
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[j] <= 1'b0;
         else if (en) dv_ff[j] <= s_v[j];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[j]   <= r_in;
            dq_ff[j]   <= q_in;
            drec_ff[j] <= s_rec[j];
         end
      end

      assign s_v[j+1]   = dv_ff[j];
      assign s_r[j+1]   = dr_ff[j];
      assign s_q[j+1]   = dq_ff[j];
      assign s_rec[j+1] = drec_ff[j];
   end

   // interior correction
   logic         cv_ff;
   logic [W-1:0] csq_ff;
   region_type   creg_ff;

   always_ff @(posedge clock) begin
      if (reset) cv_ff <= 1'b0;
      else if (en) cv_ff <= s_v[W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         csq_ff  <= (s_rec[W].region == REGION_MID) ? s_rec[W].base - s_q[W]
                                                   : s_rec[W].base;
         creg_ff <= s_rec[W].region;
      end
   end

   // square root chain: two bits of the radicand per stage
   logic          t_v    [0:RB];
   logic [W-1:0]  t_n    [0:RB];
   logic [RB:0]   t_rem  [0:RB];
   logic [RB-1:0] t_root [0:RB];
   region_type    t_reg  [0:RB];

   logic          rv_ff    [0:RB-1];
   logic [W-1:0]  rn_ff    [0:RB-1];
   logic [RB:0]   rrem_ff  [0:RB-1];
   logic [RB-1:0] rroot_ff [0:RB-1];
   region_type    rreg_ff  [0:RB-1];

   assign t_v[0]    = cv_ff;
   assign t_n[0]    = csq_ff;
   assign t_rem[0]  = '0;
   assign t_root[0] = '0;
   assign t_reg[0]  = creg_ff;

   for (genvar i = 0; i < RB; i++) begin : g_root
      logic [RB+2:0] rem_t, trial;
      logic [RB:0]   rem_in;
      logic [RB-1:0] root_in;

      always_comb begin
         rem_t = {t_rem[i], t_n[i][W-1-2*i -: 2]};
         trial = {1'b0, t_root[i], 2'b01};
         if (rem_t >= trial) begin
            rem_in  = (RB+1)'(rem_t - trial);
            root_in = {t_root[i][RB-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[RB:0];
            root_in = {t_root[i][RB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) rv_ff[i] <= 1'b0;
         else if (en) rv_ff[i] <= t_v[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rn_ff[i]    <= t_n[i];
            rrem_ff[i]  <= rem_in;
            rroot_ff[i] <= root_in;
            rreg_ff[i]  <= t_reg[i];
         end
      end

      assign t_v[i+1]    = rv_ff[i];
      assign t_n[i+1]    = rn_ff[i];
      assign t_rem[i+1]  = rrem_ff[i];
      assign t_root[i+1] = rroot_ff[i];
      assign t_reg[i+1]  = rreg_ff[i];
   end

   assign out_v                   = t_v[RB];
   assign rsp_if.valid            = out_v;
   assign rsp_if.squared_distance = t_n[RB];
   assign rsp_if.root_distance    = t_root[RB];
   assign rsp_if.region           = t_reg[RB];

endmodule

>>> sim/point_segment_distance_core_tb.sv
// Self-checking testbench for the point-to-segment squared distance core.
`timescale 1ns / 1ps
module point_segment_distance_core_tb;
   import psd_pkg::*;

   localparam int CB = 16;
   localparam int SQW = 2*CB+2;
   localparam int RTW = CB+1;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
   } point_type;

   typedef struct packed {
      logic [SQW-1:0] sq;
      logic [RTW-1:0] root;
      region_type     region;
   } distance_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   psd_req_if #(.COORD_BITS(CB)) req_if ();
   psd_rsp_if #(.COORD_BITS(CB)) rsp_if ();

   point_segment_distance_core #(.COORD_BITS(CB)) dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always #4 clock = ~clock;

   point_type    query_q[$];
   distance_type expected_q[$];
   logic signed [CB-1:0] seg_a[3];
   logic signed [CB-1:0] seg_b[3];
   int  errors = 0;
   int  results_seen = 0;
   int  region_count[3] = '{0, 0, 0};
   bit  calm = 0;
   bit  req_taken = 0;

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic distance_type segment_distance(point_type q);
      longint ab[3], ac[3], bc[3];
      longint qv[3];
      longint e, acac, bcbc, f;
      logic [127:0] e2;
      logic [63:0] sq;
      distance_type d;
      qv[0] = q.x; qv[1] = q.y; qv[2] = q.z;
      e = 0; acac = 0; bcbc = 0; f = 0;
      for (int i = 0; i < 3; i++) begin
         ab[i] = longint'(seg_b[i]) - longint'(seg_a[i]);
         ac[i] = qv[i] - longint'(seg_a[i]);
         bc[i] = qv[i] - longint'(seg_b[i]);
         e += ac[i] * ab[i];
         acac += ac[i] * ac[i];
         bcbc += bc[i] * bc[i];
         f += ab[i] * ab[i];
      end
      if (e <= 0) begin
         sq = acac;
         d.region = REGION_A;
      end else if (e >= f) begin
         sq = bcbc;
         d.region = REGION_B;
      end else begin
         e2 = 128'(e) * 128'(e);
         sq = 64'(acac) - 64'(e2 / 128'(f));
         d.region = REGION_MID;
      end
      d.sq = sq[SQW-1:0];
      d.root = RTW'(floor_sqrt(sq));
      return d;
   endfunction

   // marks a transaction taken at the last rising edge
   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
   end

   // driver: pulls from query_q at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
      end else if (req_if.valid && !req_taken) begin
         // hold the pending transaction
      end else if (query_q.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
         point_type p;
         p = query_q.pop_front();
         req_if.valid <= 1;
         req_if.query_x <= p.x;
         req_if.query_y <= p.y;
         req_if.query_z <= p.z;
         expected_q.push_back(segment_distance(p));
      end else begin
         req_if.valid <= 0;
      end
      rsp_if.ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 34);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         distance_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result sq=%0d", $time, rsp_if.squared_distance);
            errors++;
         end else begin
            want = expected_q.pop_front();
            results_seen++;
            region_count[want.region]++;
            if (rsp_if.squared_distance !== want.sq) begin
               $display("%0t: squared_distance expected %0d actual %0d", $time,
                        want.sq, rsp_if.squared_distance);
               errors++;
            end
            if (rsp_if.root_distance !== want.root) begin
               $display("%0t: root_distance expected %0d actual %0d", $time,
                        want.root, rsp_if.root_distance);
               errors++;
            end
            if (rsp_if.region !== want.region) begin
               $display("%0t: region expected %0d actual %0d", $time,
                        want.region, rsp_if.region);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic signed [CB-1:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < CSR_END_B_X) seg_a[idx] = val;
      else seg_b[idx - CSR_END_B_X] = val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic set_segment(point_type a, point_type b);
      write_reg(CSR_END_A_X, a.x);
      write_reg(CSR_END_A_Y, a.y);
      write_reg(CSR_END_A_Z, a.z);
      write_reg(CSR_END_B_X, b.x);
      write_reg(CSR_END_B_Y, b.y);
      write_reg(CSR_END_B_Z, b.z);
   endtask

   task automatic drain();
      // wait for every expected transaction, then past the pipeline depth
      while (query_q.size() > 0 || req_if.valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic point_type rand_point(int span);
      point_type p;
      if (span >= 32768) begin
         p.x = CB'($urandom); p.y = CB'($urandom); p.z = CB'($urandom);
      end else begin
         p.x = CB'(int'($urandom_range(2*span)) - span);
         p.y = CB'(int'($urandom_range(2*span)) - span);
         p.z = CB'(int'($urandom_range(2*span)) - span);
      end
      return p;
   endfunction

   localparam logic signed [CB-1:0] MINC = -32768;
   localparam logic signed [CB-1:0] MAXC = 32767;

   initial begin
      point_type a, b, p;
      seg_a = '{0, 0, 0};
      seg_b = '{1, 0, 0};
      req_if.valid = 0;
      req_if.query_x = 0; req_if.query_y = 0; req_if.query_z = 0;
      rsp_if.ready = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset segment, extremes and both endpoint regions
      query_q.push_back('{0, 0, 0});
      query_q.push_back('{1, 5, -3});
      query_q.push_back('{MAXC, MAXC, MAXC});
      query_q.push_back('{MINC, MINC, MINC});
      query_q.push_back('{MINC, MAXC, MINC});
      drain();

      // longest diagonal, interior and endpoint queries
      set_segment('{MINC, MINC, MINC}, '{MAXC, MAXC, MAXC});
      query_q.push_back('{MAXC, MINC, MINC});
      query_q.push_back('{MINC, MAXC, MAXC});
      query_q.push_back('{0, 0, 0});
      query_q.push_back('{MINC, MINC, MINC});
      query_q.push_back('{MAXC, MAXC, MAXC});
      query_q.push_back('{100, -200, 50});
      drain();

      // degenerate segment
      set_segment('{MAXC, MINC, 7}, '{MAXC, MINC, 7});
      query_q.push_back('{MINC, MAXC, MINC});
      query_q.push_back('{MAXC, MINC, 7});
      query_q.push_back('{-1, -1, -1});
      drain();

      // random phases; first one runs without idling
      for (int ph = 0; ph < 10; ph++) begin
         calm = (ph == 0);
         if (ph % 3 == 2) begin
            a = rand_point(40); b = rand_point(40);
         end else begin
            a = rand_point(32768); b = rand_point(32768);
         end
         if (ph == 5) b = a;
         set_segment(a, b);
         for (int n = 0; n < 50; n++) begin
            case ($urandom_range(3))
               0: p = rand_point(32768);
               1: p = rand_point(60);
               default: begin
                  // near the segment, mostly interior
                  int t;
                  t = $urandom_range(16);
                  p.x = CB'((longint'(a.x) * (16 - t) + longint'(b.x) * t) / 16
                            + int'($urandom_range(20)) - 10);
                  p.y = CB'((longint'(a.y) * (16 - t) + longint'(b.y) * t) / 16
                            + int'($urandom_range(20)) - 10);
                  p.z = CB'((longint'(a.z) * (16 - t) + longint'(b.z) * t) / 16
                            + int'($urandom_range(20)) - 10);
               end
            endcase
            query_q.push_back(p);
         end
         drain();
      end

      $display("covered %0d results: near A %0d, near B %0d, interior %0d",
               results_seen, region_count[0], region_count[1], region_count[2]);
      if (errors == 0) begin
         $display("point_segment_distance_core_tb: done, clean");
      end else begin
         $display("point_segment_distance_core_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("point_segment_distance_core_tb: done, errors");
      $finish;
   end

endmodule
